FILE: hw/rtl/dtct_pkg.sv
// ----------------------------------------------------------------------------
// dtct_pkg
// Shared types and constants of the delimited text cell tokenizer.
// ----------------------------------------------------------------------------
package dtct_pkg;

    localparam int LEN_W     = 10;
    localparam int POS_W     = 16;
    localparam int FIELD_MAX = 1023;
    localparam int CAP_TOP   = (1 << LEN_W) - 1;

    // lengths and fraction counts saturate here
    localparam logic [LEN_W-1:0] LEN_CAP =
        LEN_W'((FIELD_MAX < CAP_TOP) ? FIELD_MAX : CAP_TOP);

    localparam int COLUMN_LIMIT_DEF = 32;

    // character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LOWER_E = 8'h65;

    // configuration defaults
    localparam logic [1:0]  MODE_RST       = 2'd0;
    localparam logic [7:0]  FIRST_DLM_RST  = 8'd32;
    localparam logic [7:0]  SECOND_DLM_RST = 8'd9;
    localparam logic [15:0] START_ROW_RST  = 16'd0;
    localparam logic [9:0]  START_COL_RST  = 10'd0;
    localparam logic [7:0]  ROW_STEP_RST   = 8'd1;
    localparam logic [7:0]  COL_STEP_RST   = 8'd1;
    localparam logic [15:0] RUN_LEN_RST    = 16'd20000;

    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_FIRST_DLM  = 3'd1,
        REG_SECOND_DLM = 3'd2,
        REG_START_ROW  = 3'd3,
        REG_START_COL  = 3'd4,
        REG_ROW_STEP   = 3'd5,
        REG_COL_STEP   = 3'd6,
        REG_RUN_LEN    = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_TOKEN  = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_STRING = 3'd2,
        KIND_FORMAT = 3'd3,
        KIND_END    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BARE  = 2'd1,
        PH_QUOTE = 2'd2,
        PH_DELIM = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_END_UPDATE,
        ST_WALK_RD,
        ST_WALK_OUT,
        ST_END_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic upd_write;  // write back column maximum
        logic walk_rd;    // read store at walk index
        logic walk_next;  // advance walk index
        logic fmt_load;   // load column format result
        logic end_load;   // load end result, clear parse state
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;    // output register can take a result
        logic fin_now;     // offered beat closes a field
        logic eoi_now;     // offered beat is end of input
        logic walk_last;   // walk index at last column
        logic fmt_nonzero; // column read back has nonzero width
    } dp_stat_t;

endpackage

FILE: hw/rtl/dtct_col_store.sv
// ----------------------------------------------------------------------------
// dtct_col_store
// Per-column width and decimals store: one write port, one registered read
// port, all valid bits cleared at once. Invalid entries read as zero.
// ----------------------------------------------------------------------------
module dtct_col_store #(
    parameter int DEPTH = dtct_pkg::COLUMN_LIMIT_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       clear,
    input  logic                       rd_en,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic [dtct_pkg::LEN_W-1:0] rd_width,
    output logic [dtct_pkg::LEN_W-1:0] rd_dec,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_addr,
    input  logic [dtct_pkg::LEN_W-1:0] wr_width,
    input  logic [dtct_pkg::LEN_W-1:0] wr_dec
);
    import dtct_pkg::*;

    logic [LEN_W-1:0] width_mem [DEPTH];
    logic [LEN_W-1:0] dec_mem   [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [LEN_W-1:0] rd_width_reg;
    logic [LEN_W-1:0] rd_dec_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            width_mem[wr_addr] <= wr_width;
            dec_mem[wr_addr]   <= wr_dec;
        end
        if (rd_en) begin
            rd_width_reg <= width_mem[rd_addr];
            rd_dec_reg   <= dec_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_width = rd_valid_reg ? rd_width_reg : '0;
    assign rd_dec   = rd_valid_reg ? rd_dec_reg   : '0;

endmodule

FILE: hw/rtl/dtct_ctrl.sv
// ----------------------------------------------------------------------------
// dtct_ctrl
// Sequencer: takes input beats, schedules the store write-back after a field
// closes and walks the column store at end of input.
// ----------------------------------------------------------------------------
module dtct_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  dtct_pkg::dp_stat_t   stat,
    output dtct_pkg::ctrl_cmd_t  cmd
);
    import dtct_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_IDLE) && stat.out_free;
        cmd.accept = s_tvalid && s_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    if (stat.eoi_now) begin
                        state_next = stat.fin_now ? ST_END_UPDATE : ST_WALK_RD;
                    end else if (stat.fin_now) begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                cmd.upd_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_END_UPDATE: begin
                cmd.upd_write = 1'b1;
                state_next    = ST_WALK_RD;
            end
            ST_WALK_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = ST_WALK_OUT;
            end
            ST_WALK_OUT: begin
                // empty columns are skipped without a beat
                if (!stat.fmt_nonzero || stat.out_free) begin
                    cmd.fmt_load = stat.fmt_nonzero;
                    if (stat.walk_last) begin
                        state_next = ST_END_OUT;
                    end else begin
                        cmd.walk_next = 1'b1;
                        state_next    = ST_WALK_RD;
                    end
                end
            end
            ST_END_OUT: begin
                if (stat.out_free) begin
                    cmd.end_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_eoi_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && stat.eoi_now) |=> (state_reg != ST_IDLE))
        else $error("end of input did not start the column walk");

    a_walk_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK_OUT) |->
            ($past(state_reg) == ST_WALK_RD || $past(state_reg) == ST_WALK_OUT))
        else $error("walk output without a store read");

    a_end_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.end_load |=> (state_reg == ST_IDLE))
        else $error("end result not followed by idle");

endmodule

FILE: hw/rtl/dtct_datapath.sv
// ----------------------------------------------------------------------------
// dtct_datapath
// Configuration registers, field parser state, line position tracking,
// store address and write-back logic, and the output register.
// ----------------------------------------------------------------------------
module dtct_datapath #(
    parameter int COLUMN_LIMIT = dtct_pkg::COLUMN_LIMIT_DEF,
    parameter int IDX_W        = (COLUMN_LIMIT > 1) ? $clog2(COLUMN_LIMIT) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [7:0]                 s_tdata,
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata,
    output logic [2:0]                 m_tuser,
    output logic                       m_tlast,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [15:0]                cfg_data,
    input  dtct_pkg::ctrl_cmd_t        cmd,
    output dtct_pkg::dp_stat_t         stat,
    output logic                       st_clear,
    output logic                       st_rd_en,
    output logic [IDX_W-1:0]           st_rd_addr,
    input  logic [dtct_pkg::LEN_W-1:0] st_rd_width,
    input  logic [dtct_pkg::LEN_W-1:0] st_rd_dec,
    output logic                       st_wr_en,
    output logic [IDX_W-1:0]           st_wr_addr,
    output logic [dtct_pkg::LEN_W-1:0] st_wr_width,
    output logic [dtct_pkg::LEN_W-1:0] st_wr_dec
);
    import dtct_pkg::*;

    // configuration
    logic [1:0]  mode_reg;
    logic [7:0]  first_dlm_reg;
    logic [7:0]  second_dlm_reg;
    logic [15:0] start_row_reg;
    logic [9:0]  start_col_reg;
    logic [7:0]  row_step_reg;
    logic [7:0]  col_step_reg;
    logic [15:0] run_len_reg;

    // parse state
    phase_t             phase_reg, phase_next;
    logic               lsf_reg, lsf_next;
    logic [LEN_W-1:0]   fc_reg, fc_next;
    logic [LEN_W-1:0]   apc_reg, apc_next;
    logic               pt_reg, pt_next;
    logic               num_reg, num_next;
    logic [POS_W-1:0]   line_row_reg, line_row_next;
    logic [POS_W-1:0]   line_col_reg, line_col_next;
    logic [POS_W-1:0]   row_off_reg, row_off_next;
    logic [POS_W-1:0]   col_off_reg, col_off_next;
    logic [POS_W-1:0]   lines_reg, lines_next;
    logic [IDX_W-1:0]   walk_idx_reg;

    // pending store write-back
    logic               upd_en_reg;
    logic [IDX_W-1:0]   upd_idx_reg;
    logic [LEN_W-1:0]   upd_fc_reg;
    logic [LEN_W-1:0]   upd_apc_reg;
    logic               upd_num_reg;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    kind_t              out_kind_reg, out_kind_next;
    logic [7:0]         out_tok_reg, out_tok_next;
    logic [POS_W-1:0]   out_row_reg, out_row_next;
    logic [POS_W-1:0]   out_col_reg, out_col_next;
    logic               out_inr_reg, out_inr_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic [LEN_W-1:0]   out_frac_reg, out_frac_next;
    logic               out_last_reg, out_last_next;
    logic               out_load;

    // byte decode
    logic [7:0]       b;
    logic             is_nl, is_dq, is_dlm, strip;
    logic             fin, add, go_between;
    logic             bt_nl, bt_dlm, bt_q, bt_bare, tok;
    logic             dlm_count;
    phase_t           eff_phase;
    logic             eff_lsf;
    logic [LEN_W-1:0] fc_in, apc_in, fc_add, apc_add;
    logic             pt_in, num_in, ok, num_add, pt_add;
    logic [POS_W:0]   line_cnt;
    logic             wrap;
    logic [POS_W-1:0] cell_row, cell_col;
    logic             cell_inr, cell_num;
    logic [LEN_W:0]   fmt_w;
    logic [LEN_W-1:0] fmt_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_RST;
            first_dlm_reg  <= FIRST_DLM_RST;
            second_dlm_reg <= SECOND_DLM_RST;
            start_row_reg  <= START_ROW_RST;
            start_col_reg  <= START_COL_RST;
            row_step_reg   <= ROW_STEP_RST;
            col_step_reg   <= COL_STEP_RST;
            run_len_reg    <= RUN_LEN_RST;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_MODE:       mode_reg       <= cfg_data[1:0];
                REG_FIRST_DLM:  first_dlm_reg  <= cfg_data[7:0];
                REG_SECOND_DLM: second_dlm_reg <= cfg_data[7:0];
                REG_START_ROW:  start_row_reg  <= cfg_data;
                REG_START_COL:  start_col_reg  <= cfg_data[9:0];
                REG_ROW_STEP:   row_step_reg   <= cfg_data[7:0];
                REG_COL_STEP:   col_step_reg   <= cfg_data[7:0];
                REG_RUN_LEN:    run_len_reg    <= cfg_data;
            endcase
        end
    end

    assign b      = s_tdata;
    assign is_nl  = (b == CH_NEWLINE);
    assign is_dq  = (b == CH_QUOTE);
    assign is_dlm = (b == first_dlm_reg) || ((second_dlm_reg != 8'd0) && (b == second_dlm_reg));
    assign strip  = !mode_reg[1];

    // what the offered beat does to the field state
    always_comb begin
        fin        = 1'b0;
        add        = 1'b0;
        go_between = 1'b0;
        if (s_tuser) begin
            fin = (phase_reg == PH_BARE) || (phase_reg == PH_QUOTE);
        end else begin
            unique case (phase_reg)
                PH_BARE: begin
                    fin        = is_nl || is_dlm;
                    go_between = is_nl || is_dlm;
                    add        = !(is_nl || is_dlm);
                end
                PH_QUOTE: begin
                    fin        = is_dq || is_nl;
                    go_between = is_nl;
                    add        = !(is_dq || is_nl);
                end
                PH_IDLE, PH_DELIM: begin
                    go_between = 1'b1;
                end
            endcase
        end
    end

    // newline wins over delimiter, delimiter over quote
    assign bt_nl   = go_between && is_nl;
    assign bt_dlm  = go_between && !is_nl && is_dlm;
    assign bt_q    = go_between && !is_nl && !is_dlm && is_dq;
    assign bt_bare = go_between && !is_nl && !is_dlm && !is_dq;
    assign tok     = add || bt_bare;

    // a field that just closed leaves the parser between fields, off line start
    assign eff_phase = fin ? PH_IDLE : phase_reg;
    assign eff_lsf   = fin ? 1'b0 : lsf_reg;
    assign dlm_count = !((eff_phase == PH_DELIM) && strip) && !(eff_lsf && strip);

    assign fc_in   = bt_bare ? '0 : fc_reg;
    assign apc_in  = bt_bare ? '0 : apc_reg;
    assign pt_in   = bt_bare ? 1'b0 : pt_reg;
    assign num_in  = bt_bare ? 1'b1 : num_reg;
    assign ok      = ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_POINT) ||
                     (b == CH_MINUS) || (b == CH_PLUS) ||
                     ((fc_in != '0) && ((b == CH_LOWER_E) || (b == CH_UPPER_E)));
    assign num_add = num_in && ok;
    assign apc_add = (pt_in && (apc_in < LEN_CAP)) ? apc_in + LEN_W'(1) : apc_in;
    assign pt_add  = pt_in || (b == CH_POINT);
    assign fc_add  = (fc_in < LEN_CAP) ? fc_in + LEN_W'(1) : fc_in;

    assign line_cnt = {1'b0, lines_reg} + (POS_W+1)'(1);
    assign wrap     = (line_cnt >= {1'b0, run_len_reg});

    assign cell_row = line_row_reg + row_off_reg;
    assign cell_col = line_col_reg + col_off_reg;
    assign cell_inr = (cell_col < POS_W'(COLUMN_LIMIT));
    assign cell_num = (phase_reg != PH_QUOTE) && num_reg && (fc_reg != '0);

    always_comb begin
        phase_next    = phase_reg;
        lsf_next      = lsf_reg;
        fc_next       = fc_reg;
        apc_next      = apc_reg;
        pt_next       = pt_reg;
        num_next      = num_reg;
        line_row_next = line_row_reg;
        line_col_next = line_col_reg;
        row_off_next  = row_off_reg;
        col_off_next  = col_off_reg;
        lines_next    = lines_reg;
        if (cmd.end_load) begin
            phase_next    = PH_IDLE;
            lsf_next      = 1'b1;
            fc_next       = '0;
            apc_next      = '0;
            pt_next       = 1'b0;
            num_next      = 1'b1;
            line_row_next = start_row_reg;
            line_col_next = POS_W'(start_col_reg);
            row_off_next  = '0;
            col_off_next  = '0;
            lines_next    = '0;
        end else if (cmd.accept && !s_tuser) begin
            if (fin) begin
                phase_next = PH_IDLE;
                lsf_next   = 1'b0;
            end
            if (bt_nl) begin
                phase_next   = PH_IDLE;
                lsf_next     = 1'b1;
                row_off_next = '0;
                col_off_next = '0;
                lines_next   = wrap ? '0 : line_cnt[POS_W-1:0];
                if (mode_reg[0]) begin
                    if (wrap) begin
                        line_col_next = POS_W'(start_col_reg);
                        line_row_next = line_row_reg + POS_W'(row_step_reg);
                    end else begin
                        line_col_next = line_col_reg + POS_W'(col_step_reg);
                    end
                end else begin
                    if (wrap) begin
                        line_row_next = start_row_reg;
                        line_col_next = line_col_reg + POS_W'(col_step_reg);
                    end else begin
                        line_row_next = line_row_reg + POS_W'(row_step_reg);
                    end
                end
            end
            if (bt_dlm) begin
                if (dlm_count) begin
                    if (mode_reg[0]) begin
                        row_off_next = row_off_reg + POS_W'(1);
                    end else begin
                        col_off_next = col_off_reg + POS_W'(1);
                    end
                end
                phase_next = strip ? PH_DELIM : PH_IDLE;
            end
            if (bt_q) begin
                phase_next = PH_QUOTE;
                fc_next    = '0;
                apc_next   = '0;
                pt_next    = 1'b0;
                num_next   = 1'b1;
            end
            if (bt_bare) begin
                phase_next = PH_BARE;
            end
            if (tok) begin
                fc_next  = fc_add;
                apc_next = apc_add;
                pt_next  = pt_add;
                num_next = num_add;
            end
        end
        // a start position write also moves the line position
        if (cfg_we && (reg_index_t'(cfg_index) == REG_START_ROW)) begin
            line_row_next = cfg_data;
        end
        if (cfg_we && (reg_index_t'(cfg_index) == REG_START_COL)) begin
            line_col_next = POS_W'(cfg_data[9:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            lsf_reg      <= 1'b1;
            fc_reg       <= '0;
            apc_reg      <= '0;
            pt_reg       <= 1'b0;
            num_reg      <= 1'b1;
            line_row_reg <= START_ROW_RST;
            line_col_reg <= POS_W'(START_COL_RST);
            row_off_reg  <= '0;
            col_off_reg  <= '0;
            lines_reg    <= '0;
            walk_idx_reg <= '0;
            upd_en_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            lsf_reg      <= lsf_next;
            fc_reg       <= fc_next;
            apc_reg      <= apc_next;
            pt_reg       <= pt_next;
            num_reg      <= num_next;
            line_row_reg <= line_row_next;
            line_col_reg <= line_col_next;
            row_off_reg  <= row_off_next;
            col_off_reg  <= col_off_next;
            lines_reg    <= lines_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.end_load) begin
                walk_idx_reg <= '0;
            end else if (cmd.walk_next) begin
                walk_idx_reg <= walk_idx_reg + IDX_W'(1);
            end
            if (cmd.accept && fin) begin
                upd_en_reg <= cell_inr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && fin) begin
            upd_idx_reg <= cell_col[IDX_W-1:0];
            upd_fc_reg  <= fc_reg;
            upd_apc_reg <= apc_reg;
            upd_num_reg <= cell_num;
        end
    end

    // store: read in the closing cycle, max and write back in the next
    assign st_clear    = cmd.end_load;
    assign st_rd_en    = (cmd.accept && fin) || cmd.walk_rd;
    assign st_rd_addr  = cmd.walk_rd ? walk_idx_reg : cell_col[IDX_W-1:0];
    assign st_wr_en    = cmd.upd_write && upd_en_reg;
    assign st_wr_addr  = upd_idx_reg;
    assign st_wr_width = (upd_fc_reg > st_rd_width) ? upd_fc_reg : st_rd_width;
    assign st_wr_dec   = (upd_num_reg && (upd_apc_reg > st_rd_dec)) ? upd_apc_reg : st_rd_dec;

    assign fmt_w   = {1'b0, st_rd_width} + (LEN_W+1)'(1);
    assign fmt_len = (fmt_w > {1'b0, LEN_CAP}) ? LEN_CAP : fmt_w[LEN_W-1:0];

    always_comb begin
        out_load      = 1'b0;
        out_kind_next = KIND_TOKEN;
        out_tok_next  = '0;
        out_row_next  = '0;
        out_col_next  = '0;
        out_inr_next  = 1'b0;
        out_len_next  = '0;
        out_frac_next = '0;
        out_last_next = 1'b0;
        if (cmd.accept && fin) begin
            out_load      = 1'b1;
            out_kind_next = cell_num ? KIND_NUMBER : KIND_STRING;
            out_row_next  = cell_row;
            out_col_next  = cell_col;
            out_inr_next  = cell_inr;
            out_len_next  = fc_reg;
            out_frac_next = cell_num ? apc_reg : '0;
            out_last_next = !s_tuser;
        end else if (cmd.accept && tok) begin
            out_load      = 1'b1;
            out_tok_next  = b;
            out_last_next = 1'b1;
        end else if (cmd.fmt_load) begin
            out_load      = 1'b1;
            out_kind_next = KIND_FORMAT;
            out_col_next  = POS_W'(walk_idx_reg);
            out_inr_next  = 1'b1;
            out_len_next  = fmt_len;
            out_frac_next = st_rd_dec;
        end else if (cmd.end_load) begin
            out_load      = 1'b1;
            out_kind_next = KIND_END;
            out_last_next = 1'b1;
        end
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_kind_reg <= out_kind_next;
            out_tok_reg  <= out_tok_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_inr_reg  <= out_inr_next;
            out_len_reg  <= out_len_next;
            out_frac_reg <= out_frac_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_frac_reg, out_len_reg, out_inr_reg,
                       out_col_reg, out_row_reg, out_tok_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign stat.out_free    = !m_tvalid_reg || m_tready;
    assign stat.fin_now     = fin;
    assign stat.eoi_now     = s_tuser;
    assign stat.walk_last   = (walk_idx_reg == IDX_W'(COLUMN_LIMIT - 1));
    assign stat.fmt_nonzero = (st_rd_width != '0);

    a_wb_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd_write |-> $past(st_rd_en))
        else $error("store write-back without a preceding read");

    a_frac_in_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (fc_reg <= LEN_CAP) && (apc_reg <= fc_reg))
        else $error("field counters out of bounds");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.end_load |=> (phase_reg == PH_IDLE && lsf_reg &&
                          row_off_reg == '0 && col_off_reg == '0 && lines_reg == '0))
        else $error("parse state not cleared after end of input");

endmodule

FILE: hw/rtl/delimited_text_cell_tokenizer.sv
// ----------------------------------------------------------------------------
// delimited_text_cell_tokenizer
// Output: a result is registered and presented in the cycle after the beat
// that causes it. Input: token, delimiter and newline bytes are taken while
// the output register is free; a byte closing a field holds off input for
// the column store read-modify-write. End of input: an open field is written
// back, then each column is read and output if nonzero, then the end result.
// Reset (aresetn low, synchronous): config to defaults, store valid bits
// cleared in the same cycle, parser between fields at the start position.
// ----------------------------------------------------------------------------
module delimited_text_cell_tokenizer #(
    parameter int COLUMN_LIMIT = dtct_pkg::COLUMN_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] end_of_input
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] token_byte, [23:8] cell_row,
                                   // [39:24] cell_column, [40] column_in_range,
                                   // [50:41] field_length, [60:51] fraction_digits
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,   // last
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dtct_pkg::*;

    localparam int IDX_W = (COLUMN_LIMIT > 1) ? $clog2(COLUMN_LIMIT) : 1;

    ctrl_cmd_t        cmd;
    dp_stat_t         stat;
    logic             cfg_we;
    logic             st_clear;
    logic             st_rd_en;
    logic [IDX_W-1:0] st_rd_addr;
    logic [LEN_W-1:0] st_rd_width;
    logic [LEN_W-1:0] st_rd_dec;
    logic             st_wr_en;
    logic [IDX_W-1:0] st_wr_addr;
    logic [LEN_W-1:0] st_wr_width;
    logic [LEN_W-1:0] st_wr_dec;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    dtct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dtct_datapath #(
        .COLUMN_LIMIT (COLUMN_LIMIT),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .st_clear    (st_clear),
        .st_rd_en    (st_rd_en),
        .st_rd_addr  (st_rd_addr),
        .st_rd_width (st_rd_width),
        .st_rd_dec   (st_rd_dec),
        .st_wr_en    (st_wr_en),
        .st_wr_addr  (st_wr_addr),
        .st_wr_width (st_wr_width),
        .st_wr_dec   (st_wr_dec)
    );

    dtct_col_store #(
        .DEPTH (COLUMN_LIMIT),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (st_clear),
        .rd_en    (st_rd_en),
        .rd_addr  (st_rd_addr),
        .rd_width (st_rd_width),
        .rd_dec   (st_rd_dec),
        .wr_en    (st_wr_en),
        .wr_addr  (st_wr_addr),
        .wr_width (st_wr_width),
        .wr_dec   (st_wr_dec)
    );

endmodule
